// ===== rtl/core/itt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itt_pkg: shared types and constants for the IR text tokenizer
// Token kind codes, character constants, character classes and the
// line/column position update used by the tokenizer core.
// ----------------------------------------------------------------------------
package itt_pkg;

  // Field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 4;
  localparam int unsigned LineW = 24;
  localparam int unsigned ColW  = 16;

  localparam logic [LineW-1:0] LineMax = '1;
  localparam logic [ColW-1:0]  ColMax  = '1;

  // Token kind codes
  localparam logic [KindW-1:0] TokIdent   = 4'd0;
  localparam logic [KindW-1:0] TokInt     = 4'd1;
  localparam logic [KindW-1:0] TokExpNum  = 4'd2;
  localparam logic [KindW-1:0] TokArrow   = 4'd3;
  localparam logic [KindW-1:0] TokTag     = 4'd4;
  localparam logic [KindW-1:0] TokNull    = 4'd5;
  localparam logic [KindW-1:0] TokValueId = 4'd6;
  localparam logic [KindW-1:0] TokString  = 4'd7;
  localparam logic [KindW-1:0] TokEnd     = 4'd8;
  localparam logic [KindW-1:0] TokError   = 4'd9;

  // Character constants
  localparam logic [ByteW-1:0] ChMinus  = 8'h2D;  // '-'
  localparam logic [ByteW-1:0] ChGt     = 8'h3E;  // '>'
  localparam logic [ByteW-1:0] ChLt     = 8'h3C;  // '<'
  localparam logic [ByteW-1:0] ChHash   = 8'h23;  // '#'
  localparam logic [ByteW-1:0] ChPct    = 8'h25;  // '%'
  localparam logic [ByteW-1:0] ChE      = 8'h65;  // 'e'
  localparam logic [ByteW-1:0] ChUscore = 8'h5F;  // '_'
  localparam logic [ByteW-1:0] ChDot    = 8'h2E;  // '.'
  localparam logic [ByteW-1:0] ChPlus   = 8'h2B;  // '+'
  localparam logic [ByteW-1:0] ChQuote  = 8'h22;  // '"'
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;  // '\'
  localparam logic [ByteW-1:0] ChNl     = 8'h0A;
  localparam logic [ByteW-1:0] ChSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChTab    = 8'h09;
  localparam logic [ByteW-1:0] ChFf     = 8'h0C;

  // One result item
  typedef struct packed {
    logic [ByteW-1:0] text;
    logic [KindW-1:0] kind;
    logic             first;
    logic             last;
    logic [LineW-1:0] line;
    logic [ColW-1:0]  col;
  } result_t;

  // Text position
  typedef struct packed {
    logic [LineW-1:0] line;
    logic [ColW-1:0]  col;
  } pos_t;

  function automatic logic is_digit(input logic [ByteW-1:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_alpha(input logic [ByteW-1:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  endfunction

  function automatic logic is_space(input logic [ByteW-1:0] c);
    return (c == ChSpace) || (c == ChNl) || (c == ChTab) || (c == ChFf);
  endfunction

  function automatic logic is_tag(input logic [ByteW-1:0] c);
    return (c inside {8'h7B, 8'h7D, 8'h28, 8'h29, 8'h3A, 8'h3E, 8'h2C, 8'h5D,
                      8'h5B, 8'h2B, 8'h3D, 8'h3C});
  endfunction

  // Step the position past one byte; both counters saturate
  function automatic pos_t advance(input pos_t p, input logic [ByteW-1:0] c);
    pos_t r;
    r = p;
    if (c == ChNl) begin
      if (p.line != LineMax) r.line = p.line + 1'b1;
      r.col = ColW'(1);
    end else if (p.col != ColMax) begin
      r.col = p.col + 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ir_text_tokenizer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ir_text_tokenizer_core: byte-serial tokenizer for a textual IR
// Splits a byte stream into tokens and emits token text one byte late,
// with first/last marks, token kind on the last byte, and line/column.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake               Payload
// -------  ---  ----------------------  -------------------------------------
// in       in   in_valid_i / in_stall_o kind_i, char_byte_i
// out      out  out_valid_o/out_stall_i text_byte_o, token_kind_o, first_byte_o,
//                                       last_byte_o, line_number_o,
//                                       column_number_o
//
// One input transfer per cycle unless stalled. Each transfer is decoded in the
// cycle it is taken and its zero, one or two results are written to a four-entry
// result queue; the first result is visible on the next cycle. An end-of-input
// mark with a pending byte yields two results, drained at one per cycle unless
// the output stalls. in_stall_o is high at three or more queued results.
// Reset is asynchronous, active low; it clears the lexer state, sets line and
// column to 1 and empties the queue.
// ----------------------------------------------------------------------------
module ir_text_tokenizer_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        kind_i,
  input  wire logic [itt_pkg::ByteW-1:0]   char_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [itt_pkg::ByteW-1:0]        text_byte_o,
  output logic [itt_pkg::KindW-1:0]        token_kind_o,
  output logic                             first_byte_o,
  output logic                             last_byte_o,
  output logic [itt_pkg::LineW-1:0]        line_number_o,
  output logic [itt_pkg::ColW-1:0]         column_number_o
);

  // Lexer mode codes
  localparam logic [3:0] MIdle    = 4'd0;
  localparam logic [3:0] MIdent   = 4'd1;
  localparam logic [3:0] MInt     = 4'd2;
  localparam logic [3:0] MTail    = 4'd3;
  localparam logic [3:0] MExpE    = 4'd4;
  localparam logic [3:0] MLt      = 4'd5;
  localparam logic [3:0] MNull1   = 4'd6;
  localparam logic [3:0] MNull2   = 4'd7;
  localparam logic [3:0] MGt1     = 4'd8;
  localparam logic [3:0] MValueId = 4'd9;
  localparam logic [3:0] MString  = 4'd10;
  localparam logic [3:0] MDArrow  = 4'd11;
  localparam logic [3:0] MDTag    = 4'd12;
  localparam logic [3:0] MDNull   = 4'd13;
  localparam logic [3:0] MDString = 4'd14;
  localparam logic [3:0] MDError  = 4'd15;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Lexer state
  logic [3:0]                mode_q, mode_d;
  logic [itt_pkg::ByteW-1:0] hb_q, hb_d;
  logic                      hv_q, hv_d;
  logic                      hf_q, hf_d;
  logic                      nexp_q, nexp_d;
  logic                      esc_q, esc_d;
  itt_pkg::pos_t             pos_q, pos_d;

  // Result queue
  itt_pkg::result_t          q_mem_q [QDepth];
  logic [QPtrW-1:0]          wp_q, rp_q;
  logic [QCntW-1:0]          cnt_q;

  logic                      in_xfer, out_xfer;
  itt_pkg::result_t          r0, r1;
  logic [1:0]                n_res;

  function automatic logic [itt_pkg::KindW-1:0] end_kind(input logic [3:0] m,
                                                         input logic nexp);
    logic [itt_pkg::KindW-1:0] k;
    case (m)
      MIdent:   k = itt_pkg::TokIdent;
      MInt:     k = itt_pkg::TokInt;
      MTail:    k = nexp ? itt_pkg::TokExpNum : itt_pkg::TokInt;
      MExpE:    k = itt_pkg::TokExpNum;
      MLt:      k = itt_pkg::TokTag;
      MValueId: k = itt_pkg::TokValueId;
      MDArrow:  k = itt_pkg::TokArrow;
      MDTag:    k = itt_pkg::TokTag;
      MDNull:   k = itt_pkg::TokNull;
      MDString: k = itt_pkg::TokString;
      default:  k = itt_pkg::TokError;
    endcase
    return k;
  endfunction

  // Mode for the first byte of a token
  function automatic logic [3:0] start_mode(input logic [itt_pkg::ByteW-1:0] c);
    logic [3:0] m;
    if (itt_pkg::is_alpha(c) || c == itt_pkg::ChUscore)      m = MIdent;
    else if (itt_pkg::is_digit(c) || c == itt_pkg::ChMinus)  m = MInt;
    else if (c == itt_pkg::ChLt)                             m = MLt;
    else if (itt_pkg::is_tag(c))                             m = MDTag;
    else if (c == itt_pkg::ChPct)                            m = MValueId;
    else if (c == itt_pkg::ChQuote)                          m = MString;
    else                                                     m = MDError;
    return m;
  endfunction

  assign in_stall_o  = (cnt_q > QCntW'(QDepth - 2));
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_xfer    = out_valid_o && !out_stall_i;

  // Decode one transfer: next state and up to two results
  always_comb begin
    logic [itt_pkg::ByteW-1:0] c;
    logic [itt_pkg::ByteW-1:0] held_text;
    logic [3:0]                nxt;
    logic                      nxt_v;
    logic                      esc_keep;
    itt_pkg::pos_t             p1;

    c         = char_byte_i;
    held_text = (mode_q == MDNull) ? itt_pkg::ChGt : hb_q;
    p1        = itt_pkg::advance(pos_q, hb_q);
    nxt       = MIdle;
    nxt_v     = 1'b0;
    esc_keep  = 1'b0;

    mode_d = mode_q;
    hb_d   = hb_q;
    hv_d   = hv_q;
    hf_d   = hf_q;
    nexp_d = nexp_q;
    esc_d  = esc_q;
    pos_d  = pos_q;
    n_res  = 2'd0;
    r0     = '{text: held_text, kind: itt_pkg::TokIdent, first: hf_q, last: 1'b0,
               line: pos_q.line, col: pos_q.col};
    r1     = '{text: '0, kind: itt_pkg::TokEnd, first: 1'b1, last: 1'b1,
               line: p1.line, col: p1.col};

    // Continuation rules for the held byte
    case (mode_q)
      MIdent: begin
        nxt_v = itt_pkg::is_alpha(c) || itt_pkg::is_digit(c) ||
                c == itt_pkg::ChUscore || c == itt_pkg::ChDot;
        nxt   = MIdent;
      end
      MInt: begin
        if (hb_q == itt_pkg::ChMinus && hf_q && c == itt_pkg::ChGt) begin
          nxt_v = 1'b1; nxt = MDArrow;
        end else if (itt_pkg::is_digit(c)) begin
          nxt_v = 1'b1; nxt = MInt;
        end else if (c == itt_pkg::ChDot) begin
          nxt_v = 1'b1; nxt = MTail;
        end else if (c == itt_pkg::ChE) begin
          nxt_v = 1'b1; nxt = MExpE;
        end
      end
      MTail: begin
        if (itt_pkg::is_digit(c)) begin
          nxt_v = 1'b1; nxt = MTail;
        end else if (!nexp_q && c == itt_pkg::ChE) begin
          nxt_v = 1'b1; nxt = MExpE;
        end
      end
      MExpE: begin
        nxt_v = c == itt_pkg::ChPlus || c == itt_pkg::ChMinus || itt_pkg::is_digit(c);
        nxt   = MTail;
      end
      MLt: begin
        if (c == itt_pkg::ChLt) begin
          nxt_v = 1'b1; nxt = MNull2;
        end else if (c == itt_pkg::ChHash) begin
          nxt_v = 1'b1; nxt = MNull1;
        end
      end
      MNull1: begin
        nxt_v = 1'b1;
        nxt   = (c == itt_pkg::ChGt) ? MDNull : MNull1;
      end
      MNull2: begin
        nxt_v = 1'b1;
        nxt   = (c == itt_pkg::ChGt) ? MGt1 : MNull2;
      end
      MGt1: begin
        nxt_v = 1'b1;
        nxt   = MDNull;
      end
      MValueId: begin
        nxt_v = itt_pkg::is_digit(c);
        nxt   = MValueId;
      end
      MString: begin
        esc_keep = esc_q && c == itt_pkg::ChQuote;
        nxt_v    = 1'b1;
        nxt      = (c == itt_pkg::ChQuote) ? MDString : MString;
      end
      default: begin
        nxt_v = 1'b0;
      end
    endcase

    if (kind_i) begin
      // End of input: close the held byte, then the end token
      if (hv_q) begin
        r0.kind = end_kind(mode_q, nexp_q);
        r0.last = 1'b1;
        pos_d   = p1;
        n_res   = 2'd2;
      end else begin
        r0    = '{text: '0, kind: itt_pkg::TokEnd, first: 1'b1, last: 1'b1,
                  line: pos_q.line, col: pos_q.col};
        n_res = 2'd1;
      end
      hv_d   = 1'b0;
      hf_d   = 1'b0;
      mode_d = MIdle;
      nexp_d = 1'b0;
      esc_d  = 1'b0;
    end else if (!hv_q) begin
      // Start a token or skip whitespace
      if (itt_pkg::is_space(c)) begin
        pos_d = itt_pkg::advance(pos_q, c);
      end else begin
        hb_d   = c;
        hv_d   = 1'b1;
        hf_d   = 1'b1;
        nexp_d = 1'b0;
        esc_d  = 1'b0;
        mode_d = start_mode(c);
      end
    end else if (esc_keep) begin
      // Escaped quote: drop the backslash, hold the quote
      pos_d = p1;
      hb_d  = c;
      hf_d  = 1'b0;
      esc_d = 1'b0;
    end else if (nxt_v) begin
      // Token continues: emit held byte as an inner byte
      n_res  = 2'd1;
      pos_d  = p1;
      hb_d   = c;
      hf_d   = 1'b0;
      mode_d = nxt;
      if (nxt == MExpE) nexp_d = 1'b1;
      esc_d  = (nxt == MString) && (c == itt_pkg::ChBslash);
    end else begin
      // Token ends: emit held byte as last, then start on this byte unless it is blank
      n_res   = 2'd1;
      r0.kind = end_kind(mode_q, nexp_q);
      r0.last = 1'b1;
      hv_d    = 1'b0;
      hf_d    = 1'b0;
      mode_d  = MIdle;
      pos_d   = p1;
      if (itt_pkg::is_space(c)) begin
        pos_d = itt_pkg::advance(p1, c);
      end else begin
        hb_d   = c;
        hv_d   = 1'b1;
        hf_d   = 1'b1;
        nexp_d = 1'b0;
        esc_d  = 1'b0;
        mode_d = start_mode(c);
      end
    end
  end

  // Advance lexer state on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MIdle;
      hb_q     <= '0;
      hv_q     <= 1'b0;
      hf_q     <= 1'b0;
      nexp_q   <= 1'b0;
      esc_q    <= 1'b0;
      pos_q    <= '{line: itt_pkg::LineW'(1), col: itt_pkg::ColW'(1)};
    end else if (in_xfer) begin
      mode_q   <= mode_d;
      hb_q     <= hb_d;
      hv_q     <= hv_d;
      hf_q     <= hf_d;
      nexp_q   <= nexp_d;
      esc_q    <= esc_d;
      pos_q    <= pos_d;
    end
  end

  // Push results into the queue
  always_ff @(posedge clk_i) begin
    if (in_xfer && n_res != 2'd0) q_mem_q[wp_q] <= r0;
    if (in_xfer && n_res == 2'd2) q_mem_q[QPtrW'(wp_q + 1'b1)] <= r1;
  end

  // Track queue pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (in_xfer) wp_q <= QPtrW'(wp_q + n_res);
      if (out_xfer) rp_q <= QPtrW'(rp_q + 1'b1);
      cnt_q <= QCntW'(cnt_q + (in_xfer ? QCntW'(n_res) : '0) -
                      (out_xfer ? QCntW'(1) : '0));
    end
  end

  // Drive the head of the queue
  assign text_byte_o     = q_mem_q[rp_q].text;
  assign token_kind_o    = q_mem_q[rp_q].kind;
  assign first_byte_o    = q_mem_q[rp_q].first;
  assign last_byte_o     = q_mem_q[rp_q].last;
  assign line_number_o   = q_mem_q[rp_q].line;
  assign column_number_o = q_mem_q[rp_q].col;

endmodule
`default_nettype wire

// ===== tb/itt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itt_checker: token predictor and result scoreboard for the tokenizer core
// Watches both channels. Every input transfer runs through a local lexer
// model that queues the token bytes it should produce; every output transfer
// is compared field by field with the oldest queued byte.
// ----------------------------------------------------------------------------
module itt_checker
  import itt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             kind_i,
  input  logic [ByteW-1:0] char_byte_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [ByteW-1:0] text_byte_i,
  input  logic [KindW-1:0] token_kind_i,
  input  logic             first_byte_i,
  input  logic             last_byte_i,
  input  logic [LineW-1:0] line_number_i,
  input  logic [ColW-1:0]  column_number_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o,
  output logic [9:0]       kinds_seen_o
);

  // Lexer modes of the model; the "Done" modes hold a byte known to close
  typedef enum logic [3:0] {
    LxIdle, LxIdent, LxInt, LxTail, LxExpE, LxLt, LxNull1, LxNull2, LxGt1,
    LxValueId, LxString, LxDoneArrow, LxDoneTag, LxDoneNull, LxDoneString,
    LxDoneError
  } lex_mode_e;

  lex_mode_e        lx_mode;
  logic [ByteW-1:0] held_ch;
  logic             held_vld;
  logic             held_head;
  logic             seen_exp;
  logic             after_bslash;
  logic [LineW-1:0] cur_line;
  logic [ColW-1:0]  cur_col;

  result_t    tok_expected[$];
  int         mismatches = 0;
  int         n_pending  = 0;
  int         n_checked  = 0;
  logic [9:0] kinds_seen = '0;

  assign fail_count_o = mismatches;
  assign pending_o    = n_pending;
  assign checked_o    = n_checked;
  assign kinds_seen_o = kinds_seen;

  // Character classes
  function automatic logic ch_digit(input logic [ByteW-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic ch_letter(input logic [ByteW-1:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic ch_blank(input logic [ByteW-1:0] c);
    return (c == ChSpace) || (c == ChNl) || (c == ChTab) || (c == ChFf);
  endfunction

  function automatic logic ch_tag(input logic [ByteW-1:0] c);
    case (c)
      "{", "}", "(", ")", ":", ">", ",", "]", "[", "+", "=", "<": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Kind of a token closed while the lexer sits in mode m
  function automatic logic [KindW-1:0] close_kind(input lex_mode_e m);
    case (m)
      LxIdent:      return TokIdent;
      LxInt:        return TokInt;
      LxTail:       return seen_exp ? TokExpNum : TokInt;
      LxExpE:       return TokExpNum;
      LxLt:         return TokTag;
      LxValueId:    return TokValueId;
      LxDoneArrow:  return TokArrow;
      LxDoneTag:    return TokTag;
      LxDoneNull:   return TokNull;
      LxDoneString: return TokString;
      default:      return TokError;
    endcase
  endfunction

  task automatic reset_lexer();
    lx_mode      = LxIdle;
    held_ch      = '0;
    held_vld     = 1'b0;
    held_head    = 1'b0;
    seen_exp     = 1'b0;
    after_bslash = 1'b0;
    cur_line     = LineW'(1);
    cur_col      = ColW'(1);
  endtask

  // Move the position past one byte; both counters saturate
  task automatic step_pos(input logic [ByteW-1:0] c);
    if (c == ChNl) begin
      if (cur_line != LineMax) cur_line = cur_line + 1'b1;
      cur_col = ColW'(1);
    end else if (cur_col != ColMax) begin
      cur_col = cur_col + 1'b1;
    end
  endtask

  task automatic push_result(input logic [ByteW-1:0] text, input logic [KindW-1:0] kind,
                             input logic head, input logic tail);
    result_t r;
    r.text  = text;
    r.kind  = kind;
    r.first = head;
    r.last  = tail;
    r.line  = cur_line;
    r.col   = cur_col;
    tok_expected.push_back(r);
  endtask

  // Emit the held byte; the double-angle null reports its extra byte as '>'
  task automatic emit_held(input logic tail, input logic [KindW-1:0] kind);
    push_result((lx_mode == LxDoneNull) ? ChGt : held_ch, tail ? kind : '0, held_head, tail);
    step_pos(held_ch);
  endtask

  // Start a token on c, or skip it if it is whitespace
  task automatic open_token(input logic [ByteW-1:0] c);
    if (ch_blank(c)) begin
      step_pos(c);
    end else begin
      held_ch      = c;
      held_vld     = 1'b1;
      held_head    = 1'b1;
      seen_exp     = 1'b0;
      after_bslash = 1'b0;
      if (ch_letter(c) || c == ChUscore) lx_mode = LxIdent;
      else if (ch_digit(c) || c == ChMinus) lx_mode = LxInt;
      else if (c == ChLt) lx_mode = LxLt;
      else if (ch_tag(c)) lx_mode = LxDoneTag;
      else if (c == ChPct) lx_mode = LxValueId;
      else if (c == ChQuote) lx_mode = LxString;
      else lx_mode = LxDoneError;
    end
  endtask

  // Queue the results caused by one input transfer
  task automatic predict_item(input logic end_mark, input logic [ByteW-1:0] c);
    lex_mode_e nxt;
    logic      go;
    go  = 1'b0;
    nxt = LxIdle;
    if (end_mark) begin
      // close any held byte, then the end token at the current position
      if (held_vld) emit_held(1'b1, close_kind(lx_mode));
      push_result('0, TokEnd, 1'b1, 1'b1);
      held_vld     = 1'b0;
      held_head    = 1'b0;
      lx_mode      = LxIdle;
      seen_exp     = 1'b0;
      after_bslash = 1'b0;
    end else if (!held_vld) begin
      open_token(c);
    end else if (lx_mode == LxString && after_bslash && c == ChQuote) begin
      // drop the backslash, keep the quote as plain string text
      step_pos(held_ch);
      held_ch      = c;
      held_head    = 1'b0;
      after_bslash = 1'b0;
    end else begin
      case (lx_mode)
        LxIdent: begin
          go  = ch_letter(c) || ch_digit(c) || c == ChUscore || c == ChDot;
          nxt = LxIdent;
        end
        LxInt: begin
          go = 1'b1;
          if (held_ch == ChMinus && held_head && c == ChGt) nxt = LxDoneArrow;
          else if (ch_digit(c)) nxt = LxInt;
          else if (c == ChDot) nxt = LxTail;
          else if (c == ChE) nxt = LxExpE;
          else go = 1'b0;
        end
        LxTail: begin
          go = 1'b1;
          if (ch_digit(c)) nxt = LxTail;
          else if (!seen_exp && c == ChE) nxt = LxExpE;
          else go = 1'b0;
        end
        LxExpE: begin
          go  = (c == ChPlus) || (c == ChMinus) || ch_digit(c);
          nxt = LxTail;
        end
        LxLt: begin
          go = 1'b1;
          if (c == ChLt) nxt = LxNull2;
          else if (c == ChHash) nxt = LxNull1;
          else go = 1'b0;
        end
        LxNull1: begin
          go  = 1'b1;
          nxt = (c == ChGt) ? LxDoneNull : LxNull1;
        end
        LxNull2: begin
          go  = 1'b1;
          nxt = (c == ChGt) ? LxGt1 : LxNull2;
        end
        LxGt1: begin
          go  = 1'b1;
          nxt = LxDoneNull;
        end
        LxValueId: begin
          go  = ch_digit(c);
          nxt = LxValueId;
        end
        LxString: begin
          go  = 1'b1;
          nxt = (c == ChQuote) ? LxDoneString : LxString;
        end
        default: go = 1'b0;
      endcase
      if (go) begin
        // the token goes on: release the held byte as a middle byte
        emit_held(1'b0, '0);
        held_ch   = c;
        held_head = 1'b0;
        lx_mode   = nxt;
        if (nxt == LxExpE) seen_exp = 1'b1;
        after_bslash = (nxt == LxString) && (c == ChBslash);
      end else begin
        // the token ends here; c starts the next one unless it is whitespace
        emit_held(1'b1, close_kind(lx_mode));
        held_vld  = 1'b0;
        held_head = 1'b0;
        lx_mode   = LxIdle;
        open_token(c);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch at result %0d: %s", $time, n_checked, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  // Compare one output transfer with the oldest queued byte
  task automatic check_result();
    result_t want;
    if (tok_expected.size() == 0) begin
      report_mismatch($sformatf("unexpected result text %0h kind %0d",
                                text_byte_i, token_kind_i));
    end else begin
      want = tok_expected.pop_front();
      compare_field("text_byte", 32'(text_byte_i), 32'(want.text));
      compare_field("token_kind", 32'(token_kind_i), 32'(want.kind));
      compare_field("first_byte", 32'(first_byte_i), 32'(want.first));
      compare_field("last_byte", 32'(last_byte_i), 32'(want.last));
      compare_field("line_number", 32'(line_number_i), 32'(want.line));
      compare_field("column_number", 32'(column_number_i), 32'(want.col));
      if (want.last && want.kind < 10) kinds_seen[want.kind] = 1'b1;
      n_checked++;
    end
  endtask

  // Check outputs first: a byte taken at this edge cannot have left yet
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      reset_lexer();
      tok_expected.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) predict_item(kind_i, char_byte_i);
    end
    n_pending = tok_expected.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the IR text tokenizer core
// Feeds a short directed text covering every token kind and repair, then
// random token streams with noise, gaps and output stalls, and long output
// hold-offs. The checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import itt_pkg::*;

  localparam int  RandomItems   = 1000;
  localparam int  LongHold      = 80;
  localparam int  WatchdogLimit = 2000;
  localparam int  SettleCycles  = 8;
  localparam logic ItemText     = 1'b0;
  localparam logic ItemEnd      = 1'b1;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic             kind_i      = ItemText;
  logic [ByteW-1:0] char_byte_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [ByteW-1:0] text_byte_o;
  logic [KindW-1:0] token_kind_o;
  logic             first_byte_o;
  logic             last_byte_o;
  logic [LineW-1:0] line_number_o;
  logic [ColW-1:0]  column_number_o;

  logic       hold_go     = 1'b0;
  int         calm_left   = 0;
  int         lex_items   = 0;
  int         end_marks   = 0;
  int         blank_items = 0;
  int         fail_count;
  int         n_pending;
  int         n_checked;
  logic [9:0] kinds_seen;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ir_text_tokenizer_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .char_byte_i     (char_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .text_byte_o     (text_byte_o),
    .token_kind_o    (token_kind_o),
    .first_byte_o    (first_byte_o),
    .last_byte_o     (last_byte_o),
    .line_number_o   (line_number_o),
    .column_number_o (column_number_o)
  );

  itt_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .kind_i          (kind_i),
    .char_byte_i     (char_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .text_byte_i     (text_byte_o),
    .token_kind_i    (token_kind_o),
    .first_byte_i    (first_byte_o),
    .last_byte_i     (last_byte_o),
    .line_number_i   (line_number_o),
    .column_number_i (column_number_o),
    .fail_count_o    (fail_count),
    .pending_o       (n_pending),
    .checked_o       (n_checked),
    .kinds_seen_o    (kinds_seen)
  );

  // Sender gap: mostly none, some short, a few long; calm stretches have none
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item after an optional gap and hold it until the transfer
  task automatic send_item(input logic item_kind, input logic [ByteW-1:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= item_kind;
    char_byte_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    if (item_kind == ItemEnd) begin
      end_marks++;
      lex_items++;
    end else if (is_space(c)) begin
      blank_items++;
    end else begin
      lex_items++;
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(ItemText, s[i]);
  endtask

  // Stop offering until every expected result has arrived
  task automatic drain_wait();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (n_pending != 0);
    @(posedge clk_i);
  endtask

  // Hold the output off for a long stretch while tags keep coming
  task automatic fill_under_hold();
    hold_go   <= 1'b1;
    calm_left = 40;
    repeat (30) send_item(ItemText, ",");
  endtask

  function automatic logic [ByteW-1:0] rand_digit();
    return ByteW'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [ByteW-1:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? ByteW'("a" + r) : ByteW'("A" + r - 26);
  endfunction

  function automatic logic [ByteW-1:0] rand_blank();
    case ($urandom_range(0, 3))
      0:       return ChSpace;
      1:       return ChNl;
      2:       return ChTab;
      default: return ChFf;
    endcase
  endfunction

  // One random token, mostly well formed, then an optional separator
  task automatic send_random_token();
    logic [ByteW-1:0] tok[$];
    logic [ByteW-1:0] c;
    string            tags;
    int               r;
    int               n;
    logic             cut;
    tags = "{}():>,][+=<";
    cut  = 1'b0;
    r    = $urandom_range(0, 99);
    if (r < 14) begin
      // identifier
      tok.push_back(($urandom_range(0, 7) == 0) ? ChUscore : rand_letter());
      n = $urandom_range(0, 6);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0:       tok.push_back(rand_digit());
          1:       tok.push_back(ChUscore);
          2:       tok.push_back(ChDot);
          default: tok.push_back(rand_letter());
        endcase
      end
    end else if (r < 26) begin
      // integer, a lone minus now and then
      if ($urandom_range(0, 3) == 0) tok.push_back(ChMinus);
      n = (tok.size() != 0) ? $urandom_range(0, 4) : $urandom_range(1, 4);
      repeat (n) tok.push_back(rand_digit());
    end else if (r < 38) begin
      // number with an optional fraction and an optional exponent
      n = $urandom_range(1, 3);
      repeat (n) tok.push_back(rand_digit());
      if ($urandom_range(0, 1)) begin
        tok.push_back(ChDot);
        n = $urandom_range(0, 2);
        repeat (n) tok.push_back(rand_digit());
      end
      if ($urandom_range(0, 2) != 0) begin
        tok.push_back(ChE);
        case ($urandom_range(0, 2))
          0:       tok.push_back(ChPlus);
          1:       tok.push_back(ChMinus);
          default: ;
        endcase
        n = $urandom_range(0, 2);
        repeat (n) tok.push_back(rand_digit());
      end
    end else if (r < 44) begin
      tok.push_back(ChMinus);
      tok.push_back(ChGt);
    end else if (r < 56) begin
      tok.push_back(tags[$urandom_range(0, 11)]);
    end else if (r < 66) begin
      // null in either form
      tok.push_back(ChLt);
      tok.push_back($urandom_range(0, 1) ? ChHash : ChLt);
      n = $urandom_range(0, 4);
      repeat (n) begin
        c = ByteW'($urandom_range(0, 255));
        if (c == ChGt) c = "x";
        tok.push_back(c);
      end
      tok.push_back(ChGt);
      if (tok[1] == ChLt) tok.push_back(ByteW'($urandom_range(0, 255)));
    end else if (r < 74) begin
      tok.push_back(ChPct);
      n = $urandom_range(0, 3);
      repeat (n) tok.push_back(rand_digit());
    end else if (r < 86) begin
      // string with escaped quotes and stray backslashes
      tok.push_back(ChQuote);
      n = $urandom_range(0, 6);
      repeat (n) begin
        c = ByteW'($urandom_range(0, 99));
        if (c < 20) begin
          tok.push_back(ChBslash);
          tok.push_back(ChQuote);
        end else if (c < 28) begin
          tok.push_back(ChBslash);
        end else begin
          c = (c < 35) ? ByteW'($urandom_range(0, 255)) : ByteW'($urandom_range(32, 126));
          if (c == ChQuote) c = "'";
          tok.push_back(c);
        end
      end
      tok.push_back(ChQuote);
    end else if (r < 94) begin
      tok.push_back(ByteW'($urandom_range(0, 255)));
    end else if (r < 97) begin
      tok.push_back(ChQuote);
      if ($urandom_range(0, 1)) begin
        tok[0] = ChLt;
        tok.push_back($urandom_range(0, 1) ? ChHash : ChLt);
      end
      n = $urandom_range(0, 3);
      repeat (n) tok.push_back(rand_letter());
      cut = 1'b1;
    end
    foreach (tok[i]) send_item(ItemText, tok[i]);
    // broken sequences and plain end marks close with an end of input
    if (cut || r >= 97) send_item(ItemEnd, ByteW'($urandom_range(0, 255)));
    if ($urandom_range(0, 99) >= 45) begin
      n = $urandom_range(1, 2);
      repeat (n) send_item(ItemText, rand_blank());
    end
  endtask

  // Receiver: random stalls, calm stretches and the requested long hold
  initial begin : result_sink
    int run_left;
    int stall_left;
    int hold_left;
    int r;
    run_left   = 0;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go   <= 1'b0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (run_left > 0) begin
          run_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 5) begin
            run_left = $urandom_range(100, 300);
          end else begin
            run_left = $urandom_range(0, 12);
            if (r < 80) stall_left = $urandom_range(1, 2);
            else if (r < 95) stall_left = $urandom_range(3, 8);
            else stall_left = $urandom_range(20, 50);
          end
        end
      end
    end
  end

  // End the run when no transfer happens on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
             WatchdogLimit, n_pending);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int base;
    int next_drain;
    int holds_done;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every token kind, escaped quote, double-angle null,
    // unknown bytes at both ends of the range, unterminated null, two ends
    send_text("a.");
    send_text("->");
    send_text("-1e2");
    send_text("\"\\\"\"");
    send_text("<<>z");
    send_text("%5,7");
    send_item(ItemText, 8'hFF);
    send_item(ItemText, 8'h00);
    send_item(ItemText, ChNl);
    send_text("<#");
    send_item(ItemEnd, 8'hFF);
    send_item(ItemEnd, 8'h00);
    drain_wait();

    // Random token streams with pauses and two long output hold-offs
    base       = lex_items + blank_items;
    next_drain = $urandom_range(100, 250);
    holds_done = 0;
    while (lex_items + blank_items - base < RandomItems) begin
      send_random_token();
      if (holds_done < 2 && lex_items + blank_items - base >= 400 * (holds_done + 1)) begin
        fill_under_hold();
        holds_done++;
      end
      if (lex_items + blank_items - base >= next_drain) begin
        drain_wait();
        next_drain += $urandom_range(100, 250);
      end
    end

    // Short two-line tail, then a final end of input
    send_text("ab+cd");
    send_item(ItemText, ChNl);
    send_text("x9");
    send_item(ItemEnd, 8'h00);

    drain_wait();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d lexing items (%0d end marks) and %0d blanks, with output hold-offs",
             lex_items, end_marks, blank_items);
    $display("and sender pauses; %0d results checked, kinds closed %b.",
             n_checked, kinds_seen);
    if (fail_count == 0 && n_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
